/* rtl/core/button_debounce_long_press_defines.svh */
// Assertion macros for the button debounce block.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_DEFINES_SVH

`ifndef SYNTHESIS

// Clocked assertion with explicit clock and active-low reset.
`define BDLP_ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bdlp assertion failed");

// Same, on the block's own clock and reset.
`define BDLP_ASSERT(lbl, prop) \
    `BDLP_ASSERT_CLK(lbl, i_clk, i_rst_n, prop)

`else

`define BDLP_ASSERT_CLK(lbl, clk, rst_n, prop)
`define BDLP_ASSERT(lbl, prop)

`endif

`endif

/* rtl/core/bdlp_pkg.sv */
package bdlp_pkg;

    localparam int FIELD_W         = 4;   // width of every mask field
    localparam int NUM_BUTTONS_DEF = 4;
    localparam int DB_W            = 8;
    localparam int LP_W            = 16;
    localparam int ADDR_W          = 4;
    localparam int DATA_W          = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [1:0] REG_IDLE       = 2'd2;

    localparam logic [DB_W-1:0]    DEBOUNCE_RST   = 8'd3;
    localparam logic [LP_W-1:0]    LONG_PRESS_RST = 16'd100;
    localparam logic [FIELD_W-1:0] IDLE_RST       = 4'hC;

    typedef struct packed {
        logic push;
        logic rel;
        logic longp;
    } t_btn_evt;

endpackage

/* rtl/core/bdlp_button.sv */
module bdlp_button import bdlp_pkg::*; #(
    parameter logic RESET_LEVEL = 1'b0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_raw,
    input  logic            i_idle,
    input  logic [DB_W-1:0] i_db_polls,
    input  logic [LP_W-1:0] i_lp_polls,
    output t_btn_evt        o_evt
);

    logic            r_stable;
    logic [DB_W-1:0] r_db_cnt;
    logic            r_active;
    logic [LP_W-1:0] r_lp_cnt;

    logic            n_stable;
    logic [DB_W-1:0] n_db_cnt;
    logic            n_active;
    logic [LP_W-1:0] n_lp_cnt;

    logic            w_differ;
    logic [DB_W-1:0] w_db_inc;
    logic            w_flip;
    logic            w_push;
    logic            w_rel;
    logic            w_act;
    logic [LP_W-1:0] w_lp_cnt;
    logic            w_long;

    always_comb begin
        w_differ = i_raw != r_stable;
        w_db_inc = r_db_cnt + 1'b1;
        w_flip   = w_differ && (w_db_inc >= i_db_polls);
        w_push   = w_flip && (i_raw != i_idle);
        w_rel    = w_flip && (i_raw == i_idle);

        n_stable = w_flip ? i_raw : r_stable;
        n_db_cnt = (w_differ && !w_flip) ? w_db_inc : '0;

        // tracker: armed by push, counts quiet ticks, restarts from zero once past the long-press threshold
        w_act    = r_active | w_push;
        w_lp_cnt = (w_act && !w_push && !w_rel) ? r_lp_cnt + 1'b1 : r_lp_cnt;
        w_long   = w_lp_cnt > i_lp_polls;

        if (w_long) begin
            n_lp_cnt = '0;
            n_active = w_act;
        end else if (w_rel) begin
            n_lp_cnt = '0;
            n_active = 1'b0;
        end else begin
            n_lp_cnt = w_lp_cnt;
            n_active = w_act;
        end

        o_evt.push  = w_push;
        o_evt.rel   = w_rel;
        o_evt.longp = w_long;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= RESET_LEVEL;
            r_db_cnt <= '0;
            r_active <= 1'b0;
            r_lp_cnt <= '0;
        end else if (i_en) begin
            r_stable <= n_stable;
            r_db_cnt <= n_db_cnt;
            r_active <= n_active;
            r_lp_cnt <= n_lp_cnt;
        end
    end

endmodule

/* rtl/core/button_debounce_long_press.sv */
// Path: an accepted input word passes through the input register and the result register to m_axis.
// Throughput: one word per cycle; while a result waits, one more input word is
// taken into the input register, then s_axis_tready drops until it drains.
// Reset (i_rst_n, synchronous, active low): registers back to 3/100/12,
// stable levels to the idle bits of 12, all counters and trackers cleared.
`include "button_debounce_long_press_defines.svh"

module button_debounce_long_press import bdlp_pkg::*; #(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [3:0] raw_levels
    // result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [15:0]       m_axis_tdata,   // [3:0] pushed_mask,
                                              // [7:4] released_mask,
                                              // [11:8] long_press_mask
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // Buttons beyond the 4-bit fields see raw 0 and idle 0; their events
    // are computed but dropped from the masks.
    localparam int PadW = (NUM_BUTTONS > FIELD_W) ? NUM_BUTTONS : FIELD_W;
    localparam logic [PadW-1:0] RstLvl = PadW'(IDLE_RST);

    // ---------------- configuration registers ----------------
    logic [DB_W-1:0]    r_db_polls;
    logic [LP_W-1:0]    r_lp_polls;
    logic [FIELD_W-1:0] r_idle;
    logic               w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_db_polls <= DEBOUNCE_RST;
            r_lp_polls <= LONG_PRESS_RST;
            r_idle     <= IDLE_RST;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_DEBOUNCE:   r_db_polls <= pwdata[DB_W-1:0];
                REG_LONG_PRESS: r_lp_polls <= pwdata[LP_W-1:0];
                REG_IDLE:       r_idle     <= pwdata[FIELD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_DEBOUNCE:   prdata = DATA_W'(r_db_polls);
            REG_LONG_PRESS: prdata = DATA_W'(r_lp_polls);
            REG_IDLE:       prdata = DATA_W'(r_idle);
            default:        prdata = '0;
        endcase
    end

    // ---------------- input register ----------------
    // One word waits here; it is processed (and the button state updated)
    // in the cycle it moves into the result register.
    logic               r_in_valid;
    logic [FIELD_W-1:0] r_raw;
    logic               w_adv;

    assign w_adv         = r_in_valid && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_raw <= s_axis_tdata[FIELD_W-1:0];
        end
    end

    // ---------------- per-button cells ----------------
    logic [PadW-1:0] w_raw_pad;
    logic [PadW-1:0] w_idle_pad;
    logic [PadW-1:0] w_push;
    logic [PadW-1:0] w_rel;
    logic [PadW-1:0] w_long;

    assign w_raw_pad  = PadW'(r_raw);
    assign w_idle_pad = PadW'(r_idle);

    for (genvar gi = 0; gi < PadW; gi++) begin : g_btn
        if (gi < NUM_BUTTONS) begin : g_on
            t_btn_evt w_evt;

            bdlp_button #(
                .RESET_LEVEL (RstLvl[gi])
            ) u_btn (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_en       (w_adv),
                .i_raw      (w_raw_pad[gi]),
                .i_idle     (w_idle_pad[gi]),
                .i_db_polls (r_db_polls),
                .i_lp_polls (r_lp_polls),
                .o_evt      (w_evt)
            );

            assign w_push[gi] = w_evt.push;
            assign w_rel[gi]  = w_evt.rel;
            assign w_long[gi] = w_evt.longp;
        end else begin : g_off
            assign w_push[gi] = 1'b0;
            assign w_rel[gi]  = 1'b0;
            assign w_long[gi] = 1'b0;
        end
    end

    // ---------------- result register ----------------
    logic               r_out_valid;
    logic [FIELD_W-1:0] r_pushed;
    logic [FIELD_W-1:0] r_released;
    logic [FIELD_W-1:0] r_longp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pushed   <= w_push[FIELD_W-1:0];
            r_released <= w_rel[FIELD_W-1:0];
            r_longp    <= w_long[FIELD_W-1:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_longp, r_released, r_pushed};

    // ---------------- assertions ----------------
    // a button cannot both push and release on one tick
    `BDLP_ASSERT(a_push_rel_excl, !m_axis_tvalid || ((r_pushed & r_released) == '0))
    // a processed word always lands in the result register
    `BDLP_ASSERT(a_adv_fills_out, w_adv |=> m_axis_tvalid)
    // both stages full and stalled: input must be held off
    `BDLP_ASSERT(a_full_blocks, (r_in_valid && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)

endmodule
